// ===== sv/stsd_pkg.sv =====
// ----------------------------------------------------------------------------
// stsd_pkg: shared types and constants of the stepper stall detector
// Transaction structs, motor state record, opcodes and register indexes.
// ----------------------------------------------------------------------------
package stsd_pkg;

    localparam int MOTORS    = 16;
    localparam int POSITIONS = 2048;

    localparam int MOTOR_W = $clog2(MOTORS);
    localparam int POS_W   = $clog2(POSITIONS);
    localparam int CAL_AW  = MOTOR_W + POS_W;
    localparam int CAL_DEPTH = MOTORS * POSITIONS;

    localparam int SAMPLE_W = 10;
    localparam int COUNT_W  = 4;
    localparam int SUM_W    = 14;
    localparam int CFG_W    = 14;
    localparam int CFG_IDX_W = 2;

    // opcodes
    localparam logic [1:0] OP_CAL    = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_ARM    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_TOLERANCE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MARGIN         = 2'd3;

    // register reset values
    localparam logic [3:0]  WINDOW_LENGTH_RST       = 4'd12;
    localparam logic [13:0] SUM_TOLERANCE_RST       = 14'd8;
    localparam logic [9:0]  DEVIATION_THRESHOLD_RST = 10'd300;
    localparam logic [10:0] EDGE_MARGIN_RST         = 11'd200;

    typedef struct packed {
        logic [1:0]          op;
        logic [3:0]          motor_index;
        logic [10:0]         position;
        logic [SAMPLE_W-1:0] sample;
        logic [10:0]         travel_steps;
        logic                running;
    } t_in_item;

    typedef struct packed {
        logic stall_detected;
        logic motor_active;
    } t_out_item;

    typedef struct packed {
        logic               active;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
        logic [SUM_W-1:0]   prev;
    } t_motor_state;

    typedef struct packed {
        logic [3:0]  window_length;
        logic [13:0] sum_tolerance;
        logic [9:0]  deviation_threshold;
        logic [10:0] edge_margin;
    } t_cfg;

endpackage

// ===== sv/stsd_cal_mem.sv =====
// ----------------------------------------------------------------------------
// stsd_cal_mem: calibration store
// One entry per motor and position; one access per cycle, registered read.
// ----------------------------------------------------------------------------
module stsd_cal_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic                          i_re,
    input  logic [stsd_pkg::CAL_AW-1:0]   i_addr,
    input  logic [stsd_pkg::SAMPLE_W-1:0] i_wdata,
    output logic [stsd_pkg::SAMPLE_W-1:0] o_rdata
);

    logic [stsd_pkg::SAMPLE_W-1:0] r_mem [stsd_pkg::CAL_DEPTH];
    logic [stsd_pkg::SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/stsd_motor_mem.sv =====
// ----------------------------------------------------------------------------
// stsd_motor_mem: per-motor state store
// Active flag, sample count and window sums; entries never written read zero.
// ----------------------------------------------------------------------------
module stsd_motor_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_re,
    input  logic [stsd_pkg::MOTOR_W-1:0]  i_raddr,
    input  logic                          i_we,
    input  logic [stsd_pkg::MOTOR_W-1:0]  i_waddr,
    input  stsd_pkg::t_motor_state        i_wdata,
    output stsd_pkg::t_motor_state        o_rdata
);

    stsd_pkg::t_motor_state r_mem [stsd_pkg::MOTORS];
    stsd_pkg::t_motor_state r_rdata;
    logic [stsd_pkg::MOTORS-1:0] r_written;
    logic                        r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_we) begin
                r_written[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_ok <= r_written[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

// ===== sv/stsd_update.sv =====
// ----------------------------------------------------------------------------
// stsd_update: motor state update and stall decision
// Next state of one motor and the result for one transaction.
// ----------------------------------------------------------------------------
module stsd_update (
    input  stsd_pkg::t_in_item            i_item,
    input  stsd_pkg::t_motor_state        i_cur,
    input  logic [stsd_pkg::SAMPLE_W-1:0] i_cal,
    input  stsd_pkg::t_cfg                i_cfg,
    output stsd_pkg::t_motor_state        o_next,
    output stsd_pkg::t_out_item           o_result
);

    logic [stsd_pkg::SUM_W-1:0]    sum_diff;
    logic [stsd_pkg::SAMPLE_W-1:0] dev;
    logic [10:0]                   edge_dist;
    logic                          stall_cond;
    logic                          stall;

    always_comb begin
        sum_diff  = (i_cur.prev >= i_cur.sum) ? i_cur.prev - i_cur.sum
                                              : i_cur.sum - i_cur.prev;
        dev       = (i_item.sample >= i_cal) ? i_item.sample - i_cal
                                             : i_cal - i_item.sample;
        edge_dist = (i_item.position >= i_item.travel_steps)
                  ? i_item.position - i_item.travel_steps
                  : i_item.travel_steps - i_item.position;
        stall_cond = (sum_diff < i_cfg.sum_tolerance)
                  && (dev > i_cfg.deviation_threshold)
                  && (edge_dist > i_cfg.edge_margin)
                  && (i_item.position > i_cfg.edge_margin);
    end

    always_comb begin
        o_next = i_cur;
        stall  = 1'b0;
        case (i_item.op)
            stsd_pkg::OP_ARM: begin
                o_next.active = 1'b1;
            end
            stsd_pkg::OP_SAMPLE: begin
                if (i_item.running && i_cur.active) begin
                    if (i_cur.count < i_cfg.window_length) begin
                        o_next.count = i_cur.count + 1'b1;
                        o_next.sum   = i_cur.sum
                                     + {{(stsd_pkg::SUM_W-stsd_pkg::SAMPLE_W){1'b0}},
                                        i_item.sample};
                    end else if (i_cur.prev == '0) begin
                        // first full window only latches
                        o_next.prev = i_cur.sum;
                    end else begin
                        stall        = stall_cond;
                        o_next.prev  = i_cur.sum;
                        o_next.count = '0;
                        o_next.sum   = '0;
                        if (stall_cond) begin
                            o_next.active = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        o_result.stall_detected = stall;
        o_result.motor_active   = o_next.active;
    end

endmodule

// ===== sv/stepper_stall_detector.sv =====
// ----------------------------------------------------------------------------
// stepper_stall_detector: per-motor stall detector
// Usage:
//   Input channel (i_valid/o_stall, i_data) takes one transaction per cycle while
//   o_stall is low: calibrate, sample or arm. Every transaction yields exactly
//   one result on the output channel (o_valid/i_stall, o_data), in order.
//   The state store read issued at acceptance returns in the next cycle, in the
//   update stage, where the update is computed; when that stage advances it is
//   written back and loaded into the result register.
//   Throughput: one transaction per cycle while the receiver does not stall.
//   A write-back to the same motor in the cycle of a read is forwarded from a
//   bypass register. Calibrate transactions write the calibration store at
//   acceptance. Reset: active flags, counts and sums read as zero and registers
//   take their defaults at once; no clearing pass. Calibration is undefined
//   until written.
//   Receiver stall: the result register holds; with the update stage also
//   full, o_stall rises and input is held off.
//   Configuration: write i_cfg_* only while the block is idle.
// ----------------------------------------------------------------------------
module stepper_stall_detector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  stsd_pkg::t_in_item             i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output stsd_pkg::t_out_item            o_data,
    input  logic                           i_cfg_we,
    input  logic [stsd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stsd_pkg::CFG_W-1:0]     i_cfg_data
);

    stsd_pkg::t_cfg r_cfg;

    logic                   in_acc;
    logic                   s1_adv;
    logic                   r_s1_vld;
    stsd_pkg::t_in_item     r_s1_item;
    logic                   r_out_vld;
    stsd_pkg::t_out_item    r_out;

    logic                          r_fwd_vld;
    logic [stsd_pkg::MOTOR_W-1:0]  r_fwd_motor;
    stsd_pkg::t_motor_state        r_fwd_state;

    stsd_pkg::t_motor_state        mem_rd;
    stsd_pkg::t_motor_state        cur;
    stsd_pkg::t_motor_state        next_state;
    stsd_pkg::t_out_item           result;
    logic [stsd_pkg::SAMPLE_W-1:0] cal_rd;
    logic                          cal_we;
    logic                          cal_re;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length       <= stsd_pkg::WINDOW_LENGTH_RST;
            r_cfg.sum_tolerance       <= stsd_pkg::SUM_TOLERANCE_RST;
            r_cfg.deviation_threshold <= stsd_pkg::DEVIATION_THRESHOLD_RST;
            r_cfg.edge_margin         <= stsd_pkg::EDGE_MARGIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                stsd_pkg::CFG_WINDOW_LENGTH:
                    r_cfg.window_length <= i_cfg_data[3:0];
                stsd_pkg::CFG_SUM_TOLERANCE:
                    r_cfg.sum_tolerance <= i_cfg_data[13:0];
                stsd_pkg::CFG_DEVIATION_THRESHOLD:
                    r_cfg.deviation_threshold <= i_cfg_data[9:0];
                stsd_pkg::CFG_EDGE_MARGIN:
                    r_cfg.edge_margin <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    // handshake
    assign s1_adv  = r_s1_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_s1_vld && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    assign cal_we = in_acc && (i_data.op == stsd_pkg::OP_CAL);
    assign cal_re = in_acc && (i_data.op != stsd_pkg::OP_CAL);

    stsd_cal_mem u_cal_mem (
        .i_clk   (i_clk),
        .i_we    (cal_we),
        .i_re    (cal_re),
        .i_addr  ({i_data.motor_index, i_data.position}),
        .i_wdata (i_data.sample),
        .o_rdata (cal_rd)
    );

    stsd_motor_mem u_motor_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (in_acc),
        .i_raddr (i_data.motor_index),
        .i_we    (s1_adv),
        .i_waddr (r_s1_item.motor_index),
        .i_wdata (next_state),
        .o_rdata (mem_rd)
    );

    // bypass the write-back that coincided with this transaction's read
    assign cur = (r_fwd_vld && (r_fwd_motor == r_s1_item.motor_index))
               ? r_fwd_state : mem_rd;

    stsd_update u_update (
        .i_item   (r_s1_item),
        .i_cur    (cur),
        .i_cal    (cal_rd),
        .i_cfg    (r_cfg),
        .o_next   (next_state),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_fwd_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_data;
        end
        if (s1_adv) begin
            r_out       <= result;
            r_fwd_motor <= r_s1_item.motor_index;
            r_fwd_state <= next_state;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stepper stall detector
// Drives calibrate, arm, sample and spare-opcode transactions through the
// valid/stall input channel and checks every result against an in-bench
// model of the per-motor window sums, active flags and calibration store.
// Register settings change between phases, sender gaps and receiver stalls
// are random, and one phase holds the receiver off until the block backs up.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int RESET_CYCLES    = 10;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    // longest legal quiet stretch is the receiver hold-off; allow many times that
    localparam int WATCHDOG_LIMIT  = 5000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    stsd_pkg::t_in_item             i_data;
    logic                           o_valid;
    logic                           i_stall;
    stsd_pkg::t_out_item            o_data;
    logic                           i_cfg_we;
    logic [stsd_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [stsd_pkg::CFG_W-1:0]     i_cfg_data;

    stepper_stall_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // detector model state
    stsd_pkg::t_cfg                cfg_model;
    bit                            model_active [stsd_pkg::MOTORS];
    bit [stsd_pkg::COUNT_W-1:0]    model_count  [stsd_pkg::MOTORS];
    bit [stsd_pkg::SUM_W-1:0]      model_sum    [stsd_pkg::MOTORS];
    bit [stsd_pkg::SUM_W-1:0]      model_prev   [stsd_pkg::MOTORS];
    logic [stsd_pkg::SAMPLE_W-1:0] cal_value    [stsd_pkg::MOTORS][stsd_pkg::POSITIONS];
    bit                            cal_written  [stsd_pkg::MOTORS][stsd_pkg::POSITIONS];

    stsd_pkg::t_out_item pending_status [$];
    int                  errors = 0;
    int                  idle_cycles = 0;

    // traffic shaping
    bit            tx_gaps_on = 1'b1;
    int            tx_burst_left = 0;
    int            rx_hold_req = 0;
    logic [3:0]    motor_group [3];
    int            motor_level [stsd_pkg::MOTORS];
    logic [10:0]   hot_position [stsd_pkg::MOTORS][8];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int distance(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic stsd_pkg::t_out_item predict_status(stsd_pkg::t_in_item it);
        stsd_pkg::t_out_item r;
        int m, p;
        m = it.motor_index;
        p = it.position;
        r = '0;
        case (it.op)
            stsd_pkg::OP_CAL: begin
                cal_value[m][p]   = it.sample;
                cal_written[m][p] = 1'b1;
            end
            stsd_pkg::OP_ARM: begin
                model_active[m] = 1'b1;
            end
            stsd_pkg::OP_SAMPLE: begin
                if (it.running && model_active[m]) begin
                    if (model_count[m] < cfg_model.window_length) begin
                        model_count[m] = model_count[m] + 1'b1;
                        model_sum[m]   = model_sum[m] + it.sample;
                    end else if (model_prev[m] == '0) begin
                        // first full window only latches its sum
                        model_prev[m] = model_sum[m];
                    end else begin
                        if (distance(model_prev[m], model_sum[m]) < cfg_model.sum_tolerance &&
                            distance(it.sample, cal_value[m][p]) >
                                cfg_model.deviation_threshold &&
                            distance(p, it.travel_steps) > cfg_model.edge_margin &&
                            p > cfg_model.edge_margin) begin
                            r.stall_detected = 1'b1;
                            model_active[m]  = 1'b0;
                        end
                        model_prev[m]  = model_sum[m];
                        model_count[m] = '0;
                        model_sum[m]   = '0;
                    end
                end
            end
            default: ;
        endcase
        r.motor_active = model_active[m];
        return r;
    endfunction

    function automatic stsd_pkg::t_in_item make_item(logic [1:0] op, int m, int pos, int smp,
                                                     int travel, bit run);
        stsd_pkg::t_in_item it;
        it.op           = op;
        it.motor_index  = 4'(m);
        it.position     = 11'(pos);
        it.sample       = 10'(smp);
        it.travel_steps = 11'(travel);
        it.running      = run;
        return it;
    endfunction

    task automatic offer_item(stsd_pkg::t_in_item it);
        int gap;
        if (tx_gaps_on && tx_burst_left == 0) begin
            gap = $urandom_range(1, 8);
            tx_burst_left = $urandom_range(1, 24);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (tx_burst_left > 0) tx_burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_status.push_back(predict_status(it));
    endtask

    task automatic send_item(stsd_pkg::t_in_item it);
        stsd_pkg::t_in_item cal;
        // never let the block look up a calibration entry that was not written
        if (it.op != stsd_pkg::OP_CAL && !cal_written[it.motor_index][it.position]) begin
            cal        = it;
            cal.op     = stsd_pkg::OP_CAL;
            cal.sample = 10'($urandom_range(0, 1023));
            offer_item(cal);
        end
        offer_item(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [stsd_pkg::CFG_IDX_W-1:0] idx, int value);
        logic [stsd_pkg::CFG_W-1:0] data;
        data = stsd_pkg::CFG_W'($urandom);    // bits above the register width are don't-care
        case (idx)
            stsd_pkg::CFG_WINDOW_LENGTH: begin
                data[3:0] = 4'(value);
                cfg_model.window_length = 4'(value);
            end
            stsd_pkg::CFG_SUM_TOLERANCE: begin
                data = 14'(value);
                cfg_model.sum_tolerance = 14'(value);
            end
            stsd_pkg::CFG_DEVIATION_THRESHOLD: begin
                data[9:0] = 10'(value);
                cfg_model.deviation_threshold = 10'(value);
            end
            default: begin
                data[10:0] = 11'(value);
                cfg_model.edge_margin = 11'(value);
            end
        endcase
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(int wl, int tol, int thr, int margin);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(stsd_pkg::CFG_WINDOW_LENGTH, wl);
        write_reg(stsd_pkg::CFG_SUM_TOLERANCE, tol);
        write_reg(stsd_pkg::CFG_DEVIATION_THRESHOLD, thr);
        write_reg(stsd_pkg::CFG_EDGE_MARGIN, margin);
    endtask

    task automatic pick_motors();
        for (int i = 0; i < 3; i++) begin
            motor_group[i] = 4'($urandom_range(0, stsd_pkg::MOTORS - 1));
        end
        for (int m = 0; m < stsd_pkg::MOTORS; m++) begin
            motor_level[m] = $urandom_range(0, 1023);
            for (int k = 0; k < 8; k++) begin
                hot_position[m][k] = 11'($urandom_range(0, stsd_pkg::POSITIONS - 1));
            end
        end
    endtask

    // steady readings around a per-motor level keep window sums close
    function automatic stsd_pkg::t_in_item motor_sample(int m);
        stsd_pkg::t_in_item it;
        int level, travel;
        it.op          = stsd_pkg::OP_SAMPLE;
        it.motor_index = 4'(m);
        if ($urandom_range(0, 9) == 0) begin
            it.position = 11'($urandom_range(0, stsd_pkg::POSITIONS - 1));
        end else begin
            it.position = hot_position[m][$urandom_range(0, 7)];
        end
        level = motor_level[m] + $urandom_range(0, 3);
        if ($urandom_range(0, 24) == 0) level = $urandom_range(0, 1023);
        it.sample = (level > 1023) ? 10'd1023 : 10'(level);
        if ($urandom_range(0, 3) == 0) begin
            travel = $urandom_range(0, 128);
            travel = travel - 64 + it.position;
            if (travel < 0) travel = 0;
            if (travel > 2047) travel = 2047;
            it.travel_steps = 11'(travel);
        end else begin
            it.travel_steps = 11'($urandom_range(0, 2047));
        end
        it.running = ($urandom_range(0, 14) != 0);
        return it;
    endfunction

    task automatic send_traffic(int count);
        int m, r;
        stsd_pkg::t_in_item it;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                it.op           = 2'($urandom_range(0, 3));
                it.motor_index  = 4'($urandom_range(0, stsd_pkg::MOTORS - 1));
                it.position     = 11'($urandom_range(0, 2047));
                it.sample       = 10'($urandom_range(0, 1023));
                it.travel_steps = 11'($urandom_range(0, 2047));
                it.running      = 1'($urandom_range(0, 1));
                send_item(it);
            end else begin
                m = (r < 15) ? $urandom_range(0, stsd_pkg::MOTORS - 1)
                             : motor_group[$urandom_range(0, 2)];
                if (!model_active[m] && $urandom_range(0, 3) != 0) begin
                    send_item(make_item(stsd_pkg::OP_ARM, m, hot_position[m][$urandom_range(0, 7)],
                                        $urandom_range(0, 1023), $urandom_range(0, 2047),
                                        1'($urandom_range(0, 1))));
                end else begin
                    send_item(motor_sample(m));
                end
            end
        end
    endtask

    task automatic test_basic_ops();
        send_item(make_item(stsd_pkg::OP_CAL, 0, 0, 0, 0, 1'b0));
        send_item(make_item(stsd_pkg::OP_CAL, 15, 2047, 1023, 2047, 1'b1));
        send_item(make_item(stsd_pkg::OP_SAMPLE, 15, 2047, 1023, 0, 1'b1));     // not armed yet
        send_item(make_item(OP_SPARE, 15, 2047, 1023, 2047, 1'b1));
        send_item(make_item(stsd_pkg::OP_ARM, 15, 2047, 0, 2047, 1'b0));
        send_item(make_item(OP_SPARE, 15, 2047, 0, 0, 1'b0));
        send_item(make_item(stsd_pkg::OP_SAMPLE, 0, 0, 0, 0, 1'b1));
    endtask

    task automatic test_stall_sequence();
        configure(1, 8, 300, 200);
        send_item(make_item(stsd_pkg::OP_CAL, 5, 1000, 100, 0, 1'b0));
        send_item(make_item(stsd_pkg::OP_CAL, 5, 100, 100, 0, 1'b0));
        send_item(make_item(stsd_pkg::OP_CAL, 5, 1900, 100, 0, 1'b0));
        send_item(make_item(stsd_pkg::OP_ARM, 5, 1000, 0, 2047, 1'b1));
        send_item(make_item(stsd_pkg::OP_SAMPLE, 5, 1000, 500, 2047, 1'b1));
        // previous sum zero: latch
        send_item(make_item(stsd_pkg::OP_SAMPLE, 5, 1000, 500, 2047, 1'b1));
        send_item(make_item(stsd_pkg::OP_SAMPLE, 5, 1000, 900, 2047, 1'b1));   // stall
        send_item(make_item(stsd_pkg::OP_SAMPLE, 5, 1000, 900, 2047, 1'b1));   // inactive now
        send_item(make_item(stsd_pkg::OP_ARM, 5, 1000, 0, 2047, 1'b1));
        send_item(make_item(stsd_pkg::OP_SAMPLE, 5, 1000, 500, 2047, 1'b1));
        // near start of travel
        send_item(make_item(stsd_pkg::OP_SAMPLE, 5, 100, 900, 2047, 1'b1));
        send_item(make_item(stsd_pkg::OP_SAMPLE, 5, 1000, 500, 2047, 1'b1));
        // near end of travel
        send_item(make_item(stsd_pkg::OP_SAMPLE, 5, 1900, 900, 2000, 1'b1));
        // group not running
        send_item(make_item(stsd_pkg::OP_SAMPLE, 5, 1000, 900, 2047, 1'b0));
    endtask

    task automatic test_window_lowered();
        configure(3, 16383, 0, 0);
        send_item(make_item(stsd_pkg::OP_CAL, 7, 600, 0, 0, 1'b0));
        send_item(make_item(stsd_pkg::OP_ARM, 7, 600, 0, 0, 1'b0));
        repeat (3) send_item(make_item(stsd_pkg::OP_SAMPLE, 7, 600, 1023, 0, 1'b1));
        // count is now above the new length, so the window is already full
        configure(1, 16383, 0, 0);
        send_item(make_item(stsd_pkg::OP_SAMPLE, 7, 600, 1023, 0, 1'b1));
        send_item(make_item(stsd_pkg::OP_SAMPLE, 7, 600, 1023, 0, 1'b1));
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure(stsd_pkg::WINDOW_LENGTH_RST, stsd_pkg::SUM_TOLERANCE_RST,
                             stsd_pkg::DEVIATION_THRESHOLD_RST, stsd_pkg::EDGE_MARGIN_RST);
                1: configure(1, 16383, 0, 0);
                2: configure(15, 0, 1023, 2047);
                3: configure(0, 40, 100, 50);
                4: configure($urandom_range(1, 6), $urandom_range(0, 60),
                             $urandom_range(0, 400), $urandom_range(0, 300));
                default: configure(2, 30, 200, 100);
            endcase
            pick_motors();
            tx_gaps_on = (phase % 3 != 2);
            send_traffic(70);
        end
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        pick_motors();
        rx_hold_req = HOLD_OFF_CYCLES;
        tx_gaps_on  = 1'b0;
        send_traffic(40);
        tx_gaps_on  = 1'b1;
        // sender pauses until every result is back
        wait_drained();
        send_traffic(20);
    endtask

    initial begin : receiver_stalls
        int hold_left, mode, span, tick;
        hold_left = 0;
        mode      = 0;
        span      = 0;
        tick      = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(4, 80);
                end
                span--;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 1) == 0);
                    default: i_stall <= (tick % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        stsd_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_status.size() == 0) begin
                $error("unexpected result: stall_detected %0b motor_active %0b",
                       o_data.stall_detected, o_data.motor_active);
                errors++;
            end else begin
                want = pending_status.pop_front();
                if (o_data.stall_detected !== want.stall_detected) begin
                    $error("stall_detected: expected %0b, actual %0b",
                           want.stall_detected, o_data.stall_detected);
                    errors++;
                end
                if (o_data.motor_active !== want.motor_active) begin
                    $error("motor_active: expected %0b, actual %0b",
                           want.motor_active, o_data.motor_active);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cfg_model.window_length       = stsd_pkg::WINDOW_LENGTH_RST;
        cfg_model.sum_tolerance       = stsd_pkg::SUM_TOLERANCE_RST;
        cfg_model.deviation_threshold = stsd_pkg::DEVIATION_THRESHOLD_RST;
        cfg_model.edge_margin         = stsd_pkg::EDGE_MARGIN_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_stall_sequence();
        test_window_lowered();
        test_random_phases();
        test_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
